@@ rtl/tsrs_pkg.sv @@
// Package for the tab-separated record splitter.
// Holds the request payload types, status codes, character codes and limits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsrs_pkg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        clip_enable;
        logic [15:0] clip_address;
        logic        field_done;
        logic [15:0] field_slot;
        logic [15:0] field_start;
        logic [7:0]  field_length;
        logic [1:0]  status;
        logic [12:0] item_count;
        logic [16:0] used_length;
    } t_out_item;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [7:0] CHR_TAB = 8'd9;
    localparam logic [7:0] CHR_NL  = 8'd10;

    localparam logic [1:0] CFG_FIELD_COUNT = 2'd0;
    localparam logic [1:0] CFG_BUF_CAP     = 2'd1;
    localparam logic [1:0] CFG_ITEM_LIMIT  = 2'd2;

    localparam logic [4:0]  MAX_FIELDS      = 5'd16;
    localparam logic [16:0] BUFFER_BYTES    = 17'd65536;
    localparam logic [12:0] MAX_RECORDS     = 13'd4096;
    localparam logic [16:0] FIELD_LEN_LIMIT = 17'd256;
    localparam logic [7:0]  FIELD_LEN_MAX   = 8'd255;

    localparam logic [4:0]  RST_FIELD_COUNT = 5'd1;
    localparam logic [16:0] RST_BUF_CAP     = 17'd65536;
    localparam logic [12:0] RST_ITEM_LIMIT  = 13'd4096;

endpackage

`default_nettype wire

@@ rtl/tsrs_in_reg.sv @@
// Input register stage of the record splitter.
// Depends on tsrs_pkg for the request payload type.
`timescale 1ns / 1ps
`default_nettype none

module tsrs_in_reg
    import tsrs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_data,
    input  wire logic     i_adv,
    output logic          o_valid,
    output t_in_item      o_data
);

    logic     r_valid;
    t_in_item r_data;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tsrs_core.sv @@
// Splitter core: configuration registers, record state and the per-byte step.
// Depends on tsrs_pkg for payload types, codes and limits.
`timescale 1ns / 1ps
`default_nettype none

module tsrs_core
    import tsrs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        i_valid,
    input  wire t_in_item    i_data,
    input  wire logic        i_adv,
    output logic             o_has,
    output t_out_item        o_res
);

    logic [4:0]  r_field_count;
    logic [16:0] r_buf_cap;
    logic [12:0] r_item_limit;

    logic [3:0]  r_field_idx, n_field_idx;
    logic [12:0] r_rec_idx, n_rec_idx;
    logic [16:0] r_wr_pos, n_wr_pos;
    logic [16:0] r_fld_start, n_fld_start;
    logic [15:0] r_slot, n_slot;

    logic [4:0]  w_nf;
    logic [4:0]  w_nf_last;
    logic [16:0] w_cap;
    logic [12:0] w_lim;
    logic        w_last;
    logic [16:0] w_len;
    logic        w_err;
    logic        w_done;
    t_out_item   w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count <= RST_FIELD_COUNT;
            r_buf_cap     <= RST_BUF_CAP;
            r_item_limit  <= RST_ITEM_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIELD_COUNT: r_field_count <= i_cfg_data[4:0];
                CFG_BUF_CAP:     r_buf_cap     <= i_cfg_data;
                CFG_ITEM_LIMIT:  r_item_limit  <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign w_nf      = (r_field_count > MAX_FIELDS) ? MAX_FIELDS : r_field_count;
    assign w_cap     = (r_buf_cap > BUFFER_BYTES) ? BUFFER_BYTES : r_buf_cap;
    assign w_lim     = (r_item_limit > MAX_RECORDS) ? MAX_RECORDS : r_item_limit;
    assign w_nf_last = w_nf - 5'd1;
    assign w_last    = ({1'b0, r_field_idx} == w_nf_last);
    assign w_len     = r_wr_pos - r_fld_start;

    always_comb begin
        w_res       = '0;
        o_has       = 1'b0;
        w_err       = 1'b0;
        w_done      = 1'b0;
        n_field_idx = r_field_idx;
        n_rec_idx   = r_rec_idx;
        n_wr_pos    = r_wr_pos;
        n_fld_start = r_fld_start;
        n_slot      = r_slot;

        if (w_nf == 5'd0 || r_rec_idx >= w_lim || i_data.end_of_file) begin
            w_err = 1'b1;
        end else if (i_data.byte_in > CHR_NL) begin
            if (r_wr_pos >= w_cap) begin
                w_err = 1'b1;
            end else begin
                o_has               = 1'b1;
                w_res.write_enable  = 1'b1;
                w_res.write_address = r_wr_pos[15:0];
                w_res.write_data    = i_data.byte_in;
                n_wr_pos            = r_wr_pos + 17'd1;
            end
        end else if (i_data.byte_in < CHR_TAB) begin
            o_has = 1'b0;
        end else if (i_data.byte_in == CHR_NL && r_field_idx == 4'd0
                     && r_wr_pos == r_fld_start) begin
            w_done = 1'b1;
        end else if (i_data.byte_in == CHR_TAB && w_last) begin
            w_err = 1'b1;
        end else if (i_data.byte_in == CHR_NL && !w_last) begin
            w_err = 1'b1;
        end else if (r_wr_pos >= w_cap) begin
            w_err = 1'b1;
        end else begin
            o_has               = 1'b1;
            w_res.write_enable  = 1'b1;
            w_res.write_address = r_wr_pos[15:0];
            w_res.field_done    = 1'b1;
            w_res.field_slot    = r_slot;
            w_res.field_start   = r_fld_start[15:0];
            if (w_len >= FIELD_LEN_LIMIT) begin
                w_res.clip_enable  = 1'b1;
                w_res.clip_address = 16'(r_fld_start + (FIELD_LEN_LIMIT - 17'd1));
                w_res.field_length = FIELD_LEN_MAX;
            end else begin
                w_res.field_length = w_len[7:0];
            end
            n_slot      = r_slot + 16'd1;
            n_wr_pos    = r_wr_pos + 17'd1;
            n_fld_start = r_wr_pos + 17'd1;
            if (i_data.byte_in == CHR_TAB) begin
                n_field_idx = r_field_idx + 4'd1;
            end else begin
                n_field_idx = 4'd0;
                n_rec_idx   = r_rec_idx + 13'd1;
                if (n_rec_idx >= w_lim) begin
                    w_err = 1'b1;
                end
            end
        end

        if (w_err || w_done) begin
            o_has = 1'b1;
            w_res = '0;
            if (w_err) begin
                w_res.status = ST_ERROR;
            end else begin
                w_res.status      = ST_DONE;
                w_res.item_count  = r_rec_idx;
                w_res.used_length = r_wr_pos;
            end
            n_field_idx = '0;
            n_rec_idx   = '0;
            n_wr_pos    = '0;
            n_fld_start = '0;
            n_slot      = '0;
        end
    end

    assign o_res = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_idx <= '0;
            r_rec_idx   <= '0;
            r_wr_pos    <= '0;
            r_fld_start <= '0;
            r_slot      <= '0;
        end else if (i_adv && i_valid) begin
            r_field_idx <= n_field_idx;
            r_rec_idx   <= n_rec_idx;
            r_wr_pos    <= n_wr_pos;
            r_fld_start <= n_fld_start;
            r_slot      <= n_slot;
        end
    end

`ifndef NO_ASSERTIONS
    a_start_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fld_start <= r_wr_pos)
        else $error("field start beyond write position");

    a_err_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_valid && o_has && w_res.status == ST_ERROR)
        |=> (r_wr_pos == 17'd0 && r_rec_idx == 13'd0 && r_slot == 16'd0
             && r_field_idx == 4'd0))
        else $error("state not restarted after error");

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_has && w_res.field_done) |-> (w_res.write_enable && w_res.write_data == 8'd0))
        else $error("field end without zero terminator");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_valid && o_has && w_res.write_enable)
        |=> (r_wr_pos == $past(r_wr_pos) + 17'd1))
        else $error("write position did not advance by one");
`endif

endmodule

`default_nettype wire

@@ rtl/tsrs_out_reg.sv @@
// Result register of the record splitter.
// Depends on tsrs_pkg for the result payload type.
`timescale 1ns / 1ps
`default_nettype none

module tsrs_out_reg
    import tsrs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_out_item i_data,
    output logic           o_free,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    logic      r_valid;
    t_out_item r_data;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tab_separated_record_splitter.sv @@
// Tab-separated record splitter, top level.
// Byte requests enter on the in channel (valid/ready); results leave on the
// out channel (valid/ready) as one t_out_item each. A write port sets the
// field count, buffer capacity and item limit; write them only while the block
// is idle (the block does not enforce this). Each accepted byte gives zero or
// one result: a buffer write, a field report with its zero terminator and
// optional clip, a done report with record count and bytes used, or an error.
// After done or error the record state restarts; the configuration is kept.
// The input register holds the byte during the step and the result register
// captures the step's output. Throughput: one byte per cycle while the
// receiver keeps up.
// A stalled receiver holds the result register; bytes that give no result
// still pass through, and the next result-bearing byte waits in the input
// register until the result register frees.
// Reset (synchronous, active low) empties both registers, clears the record
// state and loads field count 1, capacity 65536 and item limit 4096.
// Depends on tsrs_pkg, tsrs_in_reg, tsrs_core and tsrs_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module tab_separated_record_splitter
    import tsrs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data
);

    logic      w_stg_valid;
    t_in_item  w_stg_data;
    logic      w_adv;
    logic      w_has;
    t_out_item w_res;
    logic      w_free;

    assign w_adv = w_stg_valid && (w_free || !w_has);

    tsrs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .i_adv   (w_adv),
        .o_valid (w_stg_valid),
        .o_data  (w_stg_data)
    );

    tsrs_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (w_stg_valid),
        .i_data     (w_stg_data),
        .i_adv      (w_adv),
        .o_has      (w_has),
        .o_res      (w_res)
    );

    tsrs_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv && w_has),
        .i_data  (w_res),
        .o_free  (w_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ dv/tsrs_checker.sv @@
// Checker for the tab-separated record splitter: watches the register port and
// both request channels, predicts every result and compares it field by field.
// Depends on tsrs_pkg.
`timescale 1ns / 1ps

module tsrs_checker
    import tsrs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire t_in_item    i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire t_out_item   i_out_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_fields,
    output int               o_clips,
    output int               o_dones,
    output int               o_errors
);

    logic [4:0]  cfg_fields;
    logic [16:0] cfg_cap;
    logic [12:0] cfg_limit;

    logic [3:0]  fld_idx;
    logic [12:0] rec_idx;
    logic [16:0] wr_pos;
    logic [16:0] fld_base;
    logic [15:0] slot_cnt;

    t_out_item awaited_results[$];

    int fails   = 0;
    int checked = 0;
    int fields  = 0;
    int clips   = 0;
    int dones   = 0;
    int errors  = 0;

    function automatic void clear_record();
        fld_idx  = '0;
        rec_idx  = '0;
        wr_pos   = '0;
        fld_base = '0;
        slot_cnt = '0;
    endfunction

    function automatic bit fault(output t_out_item res);
        res        = '0;
        res.status = ST_ERROR;
        clear_record();
        return 1'b1;
    endfunction

    // Returns 1 when the byte produces a result.
    function automatic bit split_step(input t_in_item req, output t_out_item res);
        int nf;
        int cap;
        int lim;
        int len;
        nf  = int'(cfg_fields);
        cap = int'(cfg_cap);
        lim = int'(cfg_limit);
        if (nf > int'(MAX_FIELDS)) nf = int'(MAX_FIELDS);
        if (cap > int'(BUFFER_BYTES)) cap = int'(BUFFER_BYTES);
        if (lim > int'(MAX_RECORDS)) lim = int'(MAX_RECORDS);
        res = '0;

        if (nf == 0 || int'(rec_idx) >= lim || req.end_of_file) return fault(res);

        if (req.byte_in > CHR_NL) begin
            if (int'(wr_pos) >= cap) return fault(res);
            res.write_enable  = 1'b1;
            res.write_address = wr_pos[15:0];
            res.write_data    = req.byte_in;
            wr_pos            = wr_pos + 17'd1;
            return 1'b1;
        end
        if (req.byte_in < CHR_TAB) return 1'b0;

        // empty line closes the sequence
        if (req.byte_in == CHR_NL && fld_idx == 0 && wr_pos == fld_base) begin
            res.status      = ST_DONE;
            res.item_count  = rec_idx;
            res.used_length = wr_pos;
            clear_record();
            return 1'b1;
        end
        if (req.byte_in == CHR_TAB && int'(fld_idx) == nf - 1) return fault(res);
        if (req.byte_in == CHR_NL && int'(fld_idx) != nf - 1) return fault(res);
        if (int'(wr_pos) >= cap) return fault(res);

        len = int'(wr_pos) - int'(fld_base);
        if (len >= int'(FIELD_LEN_LIMIT)) begin
            len              = int'(FIELD_LEN_MAX);
            res.clip_enable  = 1'b1;
            res.clip_address = 16'(int'(fld_base) + int'(FIELD_LEN_LIMIT) - 1);
        end
        res.write_enable  = 1'b1;
        res.write_address = wr_pos[15:0];
        res.write_data    = '0;
        res.field_done    = 1'b1;
        res.field_slot    = slot_cnt;
        res.field_start   = fld_base[15:0];
        res.field_length  = 8'(len);

        slot_cnt = slot_cnt + 16'd1;
        wr_pos   = wr_pos + 17'd1;
        fld_base = wr_pos;

        if (req.byte_in == CHR_TAB) begin
            fld_idx = fld_idx + 4'd1;
        end else begin
            fld_idx = '0;
            rec_idx = rec_idx + 13'd1;
            if (int'(rec_idx) >= lim) return fault(res);
        end
        return 1'b1;
    endfunction

    function automatic string show(input t_out_item r);
        return $sformatf({"we=%0d wa=%h wd=%h ce=%0d ca=%h fd=%0d slot=%h start=%h ",
                          "len=%0d st=%0d cnt=%0d used=%0d"},
                         r.write_enable, r.write_address, r.write_data, r.clip_enable,
                         r.clip_address, r.field_done, r.field_slot, r.field_start,
                         r.field_length, r.status, r.item_count, r.used_length);
    endfunction

    function automatic void note_fail(input string msg);
        fails++;
        if (fails <= 10) $display("MISMATCH %0d: %s", fails, msg);
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            cfg_fields = RST_FIELD_COUNT;
            cfg_cap    = RST_BUF_CAP;
            cfg_limit  = RST_ITEM_LIMIT;
            clear_record();
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIELD_COUNT: cfg_fields = i_cfg_data[4:0];
                    CFG_BUF_CAP:     cfg_cap    = i_cfg_data;
                    CFG_ITEM_LIMIT:  cfg_limit  = i_cfg_data[12:0];
                    default: ;
                endcase
            end
            // results first, so a request accepted on this edge cannot match here
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    note_fail($sformatf("result with none outstanding: %s", show(i_out_data)));
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (want.field_done) fields++;
                    if (want.clip_enable) clips++;
                    if (want.status == ST_DONE) dones++;
                    if (want.status == ST_ERROR) errors++;
                    if (want.write_enable  !== i_out_data.write_enable  ||
                        want.write_address !== i_out_data.write_address ||
                        want.write_data    !== i_out_data.write_data    ||
                        want.clip_enable   !== i_out_data.clip_enable   ||
                        want.clip_address  !== i_out_data.clip_address  ||
                        want.field_done    !== i_out_data.field_done    ||
                        want.field_slot    !== i_out_data.field_slot    ||
                        want.field_start   !== i_out_data.field_start   ||
                        want.field_length  !== i_out_data.field_length  ||
                        want.status        !== i_out_data.status        ||
                        want.item_count    !== i_out_data.item_count    ||
                        want.used_length   !== i_out_data.used_length) begin
                        note_fail($sformatf("result %0d\n  expected %s\n  actual   %s",
                                            checked, show(want), show(i_out_data)));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (split_step(i_in_data, want)) awaited_results.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
        o_checked    <= checked;
        o_fields     <= fields;
        o_clips      <= clips;
        o_dones      <= dones;
        o_errors     <= errors;
    end

endmodule

@@ dv/tab_separated_record_splitter_test.sv @@
// Testbench top for the tab-separated record splitter: resets the block, walks
// it through several register settings with directed and random byte requests.
// Depends on tsrs_pkg, tsrs_checker and the block's RTL.
`timescale 1ns / 1ps

module tab_separated_record_splitter_test;
    import tsrs_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = CFG_FIELD_COUNT;
    logic [16:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    t_in_item    in_data   = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    t_out_item   out_data;

    int fail_count;
    int pending;
    int checked;
    int fields;
    int clips;
    int dones;
    int errors;

    int idle_pct      = 38;
    int long_pct      = 3;
    bit hold_req      = 1'b0;
    int rec_fields    = 1;
    int sent_items    = 0;
    int settings_used = 1;
    int stall_cycles  = 0;

    tab_separated_record_splitter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    tsrs_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_fields     (fields),
        .o_clips      (clips),
        .o_dones      (dones),
        .o_errors     (errors)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
            $display("[tab_separated_record_splitter] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : receiver
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit eof);
        in_data  <= '{byte_in: b, end_of_file: eof};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_items++;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop sending and wait until every outstanding result has arrived
    task automatic settle();
        if (in_valid) in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= 17'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_phase(input int nf, input int cap, input int lim);
        settle();
        write_reg(CFG_FIELD_COUNT, nf);
        write_reg(CFG_BUF_CAP, cap);
        write_reg(CFG_ITEM_LIMIT, lim);
        rec_fields = (nf > int'(MAX_FIELDS)) ? int'(MAX_FIELDS) : nf;
        settings_used++;
    endtask

    task automatic send_field(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 5) send_byte(8'($urandom_range(0, 8)), 1'b0);
            send_byte(8'($urandom_range(11, 255)), 1'b0);
        end
    endtask

    // mostly well-formed records, with a wrong separator or end of file now and then
    task automatic send_record();
        int nf;
        int r;
        logic [7:0] sep;
        nf = (rec_fields == 0) ? $urandom_range(1, 4) : rec_fields;
        for (int f = 0; f < nf; f++) begin
            if ($urandom_range(0, 99) < long_pct) send_field($urandom_range(254, 290));
            else send_field($urandom_range(0, 6));
            sep = (f == nf - 1) ? CHR_NL : CHR_TAB;
            r = $urandom_range(0, 99);
            if (r < 2) send_byte(8'($urandom_range(0, 255)), 1'b1);
            else if (r < 7) send_byte((sep == CHR_NL) ? CHR_TAB : CHR_NL, 1'b0);
            else send_byte(sep, 1'b0);
        end
    endtask

    task automatic run_traffic(input int target);
        int start;
        int r;
        start = sent_items;
        while (sent_items - start < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 20);
            else if (r < 18) send_byte(CHR_NL, 1'b0);
            else send_record();
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // one field per record after reset
        send_byte(8'h41, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0B, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(CHR_NL, 1'b0);
        send_byte(CHR_NL, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(CHR_TAB, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(CHR_NL, 1'b0);
        send_byte(8'h71, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(CHR_NL, 1'b0);

        // two fields: short record, extra tab, empty last field
        set_phase(2, 65536, 4096);
        send_byte(8'h61, 1'b0);
        send_byte(CHR_NL, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(CHR_TAB, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(CHR_TAB, 1'b0);
        send_byte(8'h63, 1'b0);
        send_byte(CHR_TAB, 1'b0);
        send_byte(CHR_NL, 1'b0);
        send_byte(CHR_NL, 1'b0);

        idle_pct = 0;
        set_phase(1, 65536, 4096);
        run_traffic(180);
        idle_pct = 38;

        set_phase(31, 131071, 8191);
        run_traffic(100);
        hold_req = 1'b1;
        run_traffic(200);

        long_pct = 40;
        set_phase(1, 65536, 4096);
        run_traffic(600);
        long_pct = 3;

        set_phase(16, 65536, 4096);
        run_traffic(150);

        set_phase(3, 64, 3);
        run_traffic(80);
        settle();
        run_traffic(80);

        set_phase(2, 1, 1);
        run_traffic(60);
        set_phase(0, 0, 0);
        run_traffic(30);
        set_phase(5, 0, 4096);
        run_traffic(40);

        repeat (4) begin
            set_phase($urandom_range(1, 16), $urandom_range(16, 3000), $urandom_range(1, 12));
            run_traffic(80);
        end

        settle();
        repeat (6) @(posedge clk);

        $display("run: %0d bytes under %0d register settings, %0d results checked",
                 sent_items, settings_used, checked);
        $display("     %0d field reports (%0d clipped), %0d completions, %0d errors",
                 fields, clips, dones, errors);
        if (fail_count == 0 && pending == 0) begin
            $display("[tab_separated_record_splitter] OK");
        end else begin
            $display("[tab_separated_record_splitter] ERROR");
        end
        $finish;
    end

endmodule
